/* hdl/tceu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tceu_pkg;

   // rom size seen by fetch and branch checks, top level may override
   localparam int ROM_DEPTH_DEFAULT = 128;

   // data ram is fixed at 128 bytes mapped at 0x80-0xff
   localparam int RAM_DEPTH = 128;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   // entries in the queue between decode and execute
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_ADDR   = 2'd1;
   localparam logic [1:0] STATUS_BAD_OPCODE = 2'd2;
   localparam logic [1:0] STATUS_OUT_OF_ROM = 2'd3;

   typedef enum logic [3:0] {
      OP_LOAD  = 4'h0,
      OP_STORE = 4'h2,
      OP_MOVE  = 4'h4,
      OP_IMM   = 4'h5,
      OP_ADD   = 4'h6,
      OP_SUB   = 4'h7,
      OP_SHL   = 4'h8,
      OP_SHR   = 4'h9,
      OP_TEST  = 4'hA,
      OP_OUT   = 4'hC,
      OP_IN    = 4'hD,
      OP_BZ    = 4'hE,
      OP_JMP   = 4'hF
   } op_type;

   typedef enum logic {
      ST_EXEC,
      ST_LOAD_WAIT
   } state_type;

   // decoded instruction as it travels through the queue
   typedef struct packed {
      op_type     op;
      logic       illegal;
      logic [1:0] x;
      logic [1:0] y;
      logic [3:0] imm;
      logic [7:0] in_value;
   } decoded_type;

   function automatic logic [7:0] sel_reg(input logic [7:0] r0, input logic [7:0] r1,
                                          input logic [7:0] r2, input logic [7:0] r3,
                                          input logic [1:0] idx);
      logic [7:0] v;
      unique case (idx)
         2'd0:    v = r0;
         2'd1:    v = r1;
         2'd2:    v = r2;
         default: v = r3;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* hdl/tceu_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tceu_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_instr_byte,
   input  wire logic [7:0]           req_in_value,
   output logic                      dec_valid,
   input  wire logic                 dec_ready,
   output tceu_pkg::decoded_type     dec_data
);

   tceu_pkg::decoded_type dec;

   // opcode classification, undefined opcodes are flagged
   always_comb begin
      dec          = '0;
      dec.op       = tceu_pkg::OP_LOAD;
      dec.illegal  = 1'b0;
      dec.x        = req_instr_byte[3:2];
      dec.y        = req_instr_byte[1:0];
      dec.imm      = req_instr_byte[3:0];
      dec.in_value = req_in_value;
      unique case (req_instr_byte[7:4])
         4'h0:    dec.op = tceu_pkg::OP_LOAD;
         4'h2:    dec.op = tceu_pkg::OP_STORE;
         4'h4:    dec.op = tceu_pkg::OP_MOVE;
         4'h5:    dec.op = tceu_pkg::OP_IMM;
         4'h6:    dec.op = tceu_pkg::OP_ADD;
         4'h7:    dec.op = tceu_pkg::OP_SUB;
         4'h8:    dec.op = tceu_pkg::OP_SHL;
         4'h9:    dec.op = tceu_pkg::OP_SHR;
         4'hA:    dec.op = tceu_pkg::OP_TEST;
         4'hC:    dec.op = tceu_pkg::OP_OUT;
         4'hD:    dec.op = tceu_pkg::OP_IN;
         4'hE:    dec.op = tceu_pkg::OP_BZ;
         4'hF:    dec.op = tceu_pkg::OP_JMP;
         default: dec.illegal = 1'b1;
      endcase
   end

   assign dec_valid = req_valid;
   assign dec_data  = dec;
   assign req_ready = dec_ready;

   // a dropped item would show as valid falling without a handshake
   property p_valid_holds;
      @(posedge clock) disable iff (reset)
         req_valid && !req_ready |=> req_valid;
   endproperty
   a_valid_holds: assert property (p_valid_holds)
      else $error("request valid dropped before acceptance");

endmodule

`default_nettype wire

/* hdl/tceu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tceu_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_valid,
   output logic                      wr_ready,
   input  wire tceu_pkg::decoded_type wr_data,
   output logic                      rd_valid,
   input  wire logic                 rd_pop,
   output tceu_pkg::decoded_type     rd_data
);

   localparam int DEPTH = tceu_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   tceu_pkg::decoded_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign wr_ready = (count_ff != CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* hdl/tceu_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tceu_back #(
   parameter int ROM_DEPTH = tceu_pkg::ROM_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire tceu_pkg::decoded_type head,
   output logic                       head_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_next_pc,
   output logic                       rsp_out_valid,
   output logic [7:0]                 rsp_out_value,
   output logic                       rsp_zero_flag,
   output logic                       rsp_carry_flag,
   output logic [1:0]                 rsp_exec_status,
   output logic                       rsp_halted
);

   localparam logic [8:0] ROM_LIMIT = 9'(ROM_DEPTH);
   localparam int         AW        = tceu_pkg::RAM_AW;

   tceu_pkg::state_type state_ff, state_in;

   // architectural state
   logic [7:0] pc_ff, pc_in;
   logic [7:0] rf0_ff, rf1_ff, rf2_ff, rf3_ff;
   logic       zero_ff, zero_in;
   logic       carry_ff, carry_in;
   logic       stopped_ff, stopped_in;

   // data ram with a valid bit per byte, unwritten bytes read as zero
   logic [7:0]            ram_mem [tceu_pkg::RAM_DEPTH];
   logic [tceu_pkg::RAM_DEPTH-1:0] ram_valid_ff;
   logic [7:0]            ram_rd_data_ff;
   logic                  ram_rd_hit_ff;
   logic [7:0]            load_data;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_next_pc_ff;
   logic       rsp_out_valid_ff;
   logic [7:0] rsp_out_value_ff;
   logic       rsp_zero_ff;
   logic       rsp_carry_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_halted_ff;

   logic       out_free;
   logic       commit;
   logic       issue_load;
   logic       ram_we;
   logic [AW-1:0] ram_addr;
   logic       rf_we;
   logic [1:0] rf_idx;
   logic [7:0] rf_data;
   logic [1:0] status;
   logic       ovalid;
   logic [7:0] ovalue;
   logic [7:0] ra, rb, nxt;
   logic [8:0] sum9, diff9;
   logic       in_rom;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ra        = tceu_pkg::sel_reg(rf0_ff, rf1_ff, rf2_ff, rf3_ff, head.x);
   assign rb        = tceu_pkg::sel_reg(rf0_ff, rf1_ff, rf2_ff, rf3_ff, head.y);
   assign nxt       = 8'(pc_ff + 8'd1);
   assign sum9      = {1'b0, ra} + {1'b0, rb};
   assign diff9     = {1'b0, ra} - {1'b0, rb};
   assign in_rom    = ({1'b0, pc_ff} < ROM_LIMIT);
   assign ram_addr  = rb[AW-1:0];
   assign load_data = ram_rd_hit_ff ? ram_rd_data_ff : 8'd0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tceu_pkg::ST_EXEC:      if (issue_load) state_in = tceu_pkg::ST_LOAD_WAIT;
         tceu_pkg::ST_LOAD_WAIT: if (out_free) state_in = tceu_pkg::ST_EXEC;
         default:                state_in = tceu_pkg::ST_EXEC;
      endcase
   end

   // execute
   always_comb begin
      pc_in      = pc_ff;
      zero_in    = zero_ff;
      carry_in   = carry_ff;
      stopped_in = stopped_ff;
      rf_we      = 1'b0;
      rf_idx     = head.y;
      rf_data    = 8'd0;
      ram_we     = 1'b0;
      issue_load = 1'b0;
      status     = tceu_pkg::STATUS_OK;
      ovalid     = 1'b0;
      ovalue     = 8'd0;
      commit     = 1'b0;
      if (state_ff == tceu_pkg::ST_LOAD_WAIT) begin
         commit  = out_free;
         rf_we   = 1'b1;
         rf_idx  = 2'd0;
         rf_data = load_data;
         zero_in = (load_data == 8'd0);
         pc_in   = nxt;
      end else if (head_valid) begin
         priority if (stopped_ff) begin
            // halted: item ignored
         end else if (!in_rom) begin
            stopped_in = 1'b1;
            status     = tceu_pkg::STATUS_OUT_OF_ROM;
         end else if (head.illegal) begin
            stopped_in = 1'b1;
            status     = tceu_pkg::STATUS_BAD_OPCODE;
         end else begin
            unique case (head.op)
               tceu_pkg::OP_LOAD, tceu_pkg::OP_STORE: begin
                  if (!rb[7]) begin
                     status = tceu_pkg::STATUS_BAD_ADDR;
                  end else if (head.op == tceu_pkg::OP_LOAD) begin
                     issue_load = 1'b1;
                  end else begin
                     ram_we  = 1'b1;
                     zero_in = (rf0_ff == 8'd0);
                     pc_in   = nxt;
                  end
               end
               tceu_pkg::OP_MOVE: begin
                  rf_we   = 1'b1;
                  rf_data = ra;
                  zero_in = (ra == 8'd0);
                  pc_in   = nxt;
               end
               tceu_pkg::OP_IMM: begin
                  rf_we   = 1'b1;
                  rf_idx  = 2'd0;
                  rf_data = {4'd0, head.imm};
                  zero_in = (head.imm == 4'd0);
                  pc_in   = nxt;
               end
               tceu_pkg::OP_ADD: begin
                  rf_we    = 1'b1;
                  rf_idx   = head.x;
                  rf_data  = sum9[7:0];
                  zero_in  = (sum9[7:0] == 8'd0);
                  carry_in = sum9[8];
                  pc_in    = nxt;
               end
               tceu_pkg::OP_SUB: begin
                  rf_we    = 1'b1;
                  rf_idx   = head.x;
                  rf_data  = diff9[7:0];
                  zero_in  = (diff9[7:0] == 8'd0);
                  carry_in = diff9[8];
                  pc_in    = nxt;
               end
               tceu_pkg::OP_SHL: begin
                  rf_we   = 1'b1;
                  rf_data = {rb[3:0], 4'd0};
                  pc_in   = nxt;
               end
               tceu_pkg::OP_SHR: begin
                  rf_we   = 1'b1;
                  rf_data = {4'd0, rb[7:4]};
                  pc_in   = nxt;
               end
               tceu_pkg::OP_TEST: begin
                  zero_in = (rb == 8'd0);
                  pc_in   = nxt;
               end
               tceu_pkg::OP_OUT: begin
                  ovalid = 1'b1;
                  ovalue = rb;
                  pc_in  = nxt;
               end
               tceu_pkg::OP_IN: begin
                  rf_we   = 1'b1;
                  rf_data = head.in_value;
                  zero_in = (head.in_value == 8'd0);
                  pc_in   = nxt;
               end
               tceu_pkg::OP_BZ, tceu_pkg::OP_JMP: begin
                  if (head.op == tceu_pkg::OP_BZ && !zero_ff) begin
                     pc_in = nxt;
                  end else if ({1'b0, rb} < ROM_LIMIT) begin
                     pc_in = rb;
                  end else begin
                     stopped_in = 1'b1;
                     status     = tceu_pkg::STATUS_OUT_OF_ROM;
                  end
               end
               default: begin
                  stopped_in = 1'b1;
                  status     = tceu_pkg::STATUS_BAD_OPCODE;
               end
            endcase
         end
         commit = out_free && !issue_load;
      end
   end

   assign head_pop = commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tceu_pkg::ST_EXEC;
         pc_ff        <= 8'd0;
         rf0_ff       <= 8'd0;
         rf1_ff       <= 8'd0;
         rf2_ff       <= 8'd0;
         rf3_ff       <= 8'd0;
         zero_ff      <= 1'b0;
         carry_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
         ram_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            pc_ff      <= pc_in;
            zero_ff    <= zero_in;
            carry_ff   <= carry_in;
            stopped_ff <= stopped_in;
            if (rf_we) begin
               unique case (rf_idx)
                  2'd0:    rf0_ff <= rf_data;
                  2'd1:    rf1_ff <= rf_data;
                  2'd2:    rf2_ff <= rf_data;
                  default: rf3_ff <= rf_data;
               endcase
            end
            if (ram_we) begin
               ram_valid_ff[ram_addr] <= 1'b1;
            end
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ram array and its registered read port
   always_ff @(posedge clock) begin
      if (commit && ram_we) begin
         ram_mem[ram_addr] <= rf0_ff;
      end
      if (issue_load) begin
         ram_rd_data_ff <= ram_mem[ram_addr];
         ram_rd_hit_ff  <= ram_valid_ff[ram_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_next_pc_ff   <= pc_in;
         rsp_out_valid_ff <= ovalid;
         rsp_out_value_ff <= ovalue;
         rsp_zero_ff      <= zero_in;
         rsp_carry_ff     <= carry_in;
         rsp_status_ff    <= status;
         rsp_halted_ff    <= stopped_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_out_valid   = rsp_out_valid_ff;
   assign rsp_out_value   = rsp_out_value_ff;
   assign rsp_zero_flag   = rsp_zero_ff;
   assign rsp_carry_flag  = rsp_carry_ff;
   assign rsp_exec_status = rsp_status_ff;
   assign rsp_halted      = rsp_halted_ff;

   property p_halt_sticks;
      @(posedge clock) disable iff (reset)
         stopped_ff |=> stopped_ff;
   endproperty
   a_halt_sticks: assert property (p_halt_sticks)
      else $error("halt cleared without reset");

   property p_wait_has_head;
      @(posedge clock) disable iff (reset)
         state_ff == tceu_pkg::ST_LOAD_WAIT |-> head_valid && !stopped_ff;
   endproperty
   a_wait_has_head: assert property (p_wait_has_head)
      else $error("load wait without a pending load");

   property p_halted_frozen;
      @(posedge clock) disable iff (reset)
         stopped_ff && commit |=> $stable(pc_ff) && $stable(rf0_ff) && $stable(zero_ff);
   endproperty
   a_halted_frozen: assert property (p_halted_frozen)
      else $error("state changed while halted");

   property p_output_ok;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_out_valid_ff |-> rsp_status_ff == tceu_pkg::STATUS_OK;
   endproperty
   a_output_ok: assert property (p_output_ok)
      else $error("output byte with error status");

endmodule

`default_nettype wire

/* hdl/toy_cpu_instruction_execute_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// toy accumulator cpu execute unit
// req channel: one instruction byte per item, plus the byte used by the input
//   instruction; req_ready is high whenever the decode queue has room
// rsp channel: one result item per request item, in order: next pc, output
//   byte, flags, status and halt bit after that instruction
// the front decodes each item into a four entry queue; the back executes the
//   queue head against the registers, flags, pc and the 128 byte data ram
// an accepted request item is written into the queue, executed from the queue head
//   and its result held in the output register; a load also passes the ram read port
// throughput: one item per cycle while rsp_ready is high; a load holds the back
//   in a wait state since the ram read port is registered
// when rsp_ready is low the result waits in the output register, the back
//   stalls and the queue keeps taking items until it is full
// reset: pc, registers and flags go to zero, the halt bit clears and every
//   ram byte reads as zero until written (per-byte valid bits, no sweep)
// once halted, every later item is still answered but changes nothing

module toy_cpu_instruction_execute_unit #(
   parameter int ROM_DEPTH = tceu_pkg::ROM_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_instr_byte,
   input  wire logic [7:0] req_in_value,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_next_pc,
   output logic            rsp_out_valid,
   output logic [7:0]      rsp_out_value,
   output logic            rsp_zero_flag,
   output logic            rsp_carry_flag,
   output logic [1:0]      rsp_exec_status,
   output logic            rsp_halted
);

   // decoded items between front and queue
   logic                  dec_valid;
   logic                  dec_ready;
   tceu_pkg::decoded_type dec_data;

   // queue head toward the back
   logic                  head_valid;
   logic                  head_pop;
   tceu_pkg::decoded_type head_data;

   tceu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_instr_byte (req_instr_byte),
      .req_in_value   (req_in_value),
      .dec_valid      (dec_valid),
      .dec_ready      (dec_ready),
      .dec_data       (dec_data)
   );

   tceu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (dec_valid),
      .wr_ready (dec_ready),
      .wr_data  (dec_data),
      .rd_valid (head_valid),
      .rd_pop   (head_pop),
      .rd_data  (head_data)
   );

   // execute stage with output register
   tceu_back #(
      .ROM_DEPTH (ROM_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head_data),
      .head_pop        (head_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_value   (rsp_out_value),
      .rsp_zero_flag   (rsp_zero_flag),
      .rsp_carry_flag  (rsp_carry_flag),
      .rsp_exec_status (rsp_exec_status),
      .rsp_halted      (rsp_halted)
   );

endmodule

`default_nettype wire
